>>> hdl/kdh_pkg.sv
// ----------------------------------------------------------------------------
// Key debounce and hold detector package
// Shared constants, register indexes, event codes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package kdh_pkg;

	localparam int MAX_KEYS   = 3;
	localparam int NUM_KEYS   = 3;
	localparam int TIME_WIDTH = 32;
	localparam int HOLD_W     = 32;
	localparam int COUNT_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MIN = 7'd2;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd100;

	localparam logic [HOLD_W-1:0]  HOLD_RESET    = 32'd2000;
	localparam logic [MAX_KEYS-1:0] ACTIVE_RESET = 3'd0;
	localparam logic [COUNT_W-1:0] PRESS_RESET   = 7'd90;
	localparam logic [COUNT_W-1:0] RELEASE_RESET = 7'd30;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR   = 3'd5;

	typedef enum logic [1:0] {
		EV_RELEASED = 2'd0,
		EV_PRESSED  = 2'd1,
		EV_HELD     = 2'd2
	} kdh_event_t;

	typedef struct packed {
		logic [HOLD_W-1:0]  hold_time;
		logic               active_level;
		logic [COUNT_W-1:0] press_thr;
		logic [COUNT_W-1:0] release_thr;
	} kdh_key_cfg_t;

	typedef struct packed {
		logic [2:0]  pin_levels;
		logic [31:0] now_time;
	} kdh_in_t;

	typedef struct packed {
		logic [1:0] key0_event;
		logic [1:0] key1_event;
		logic [1:0] key2_event;
		logic [2:0] keys_down;
	} kdh_out_t;

endpackage

`default_nettype wire

>>> hdl/kdh_cfg.sv
// ----------------------------------------------------------------------------
// Key debounce configuration registers
// Holds the per-key hold intervals, active levels and the two thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module kdh_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [kdh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [kdh_pkg::CFG_DATA_W-1:0]    cfg_data,
	output kdh_pkg::kdh_key_cfg_t                  key_cfg [kdh_pkg::MAX_KEYS]
);

	logic [kdh_pkg::HOLD_W-1:0]   hold_q [kdh_pkg::MAX_KEYS];
	logic [kdh_pkg::MAX_KEYS-1:0] active_q;
	logic [kdh_pkg::COUNT_W-1:0]  press_q;
	logic [kdh_pkg::COUNT_W-1:0]  release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < kdh_pkg::MAX_KEYS; k++) begin
				hold_q[k] <= kdh_pkg::HOLD_RESET;
			end
			active_q  <= kdh_pkg::ACTIVE_RESET;
			press_q   <= kdh_pkg::PRESS_RESET;
			release_q <= kdh_pkg::RELEASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kdh_pkg::REG_HOLD_KEY0:     hold_q[0] <= cfg_data[kdh_pkg::HOLD_W-1:0];
				kdh_pkg::REG_HOLD_KEY1:     hold_q[1] <= cfg_data[kdh_pkg::HOLD_W-1:0];
				kdh_pkg::REG_HOLD_KEY2:     hold_q[2] <= cfg_data[kdh_pkg::HOLD_W-1:0];
				kdh_pkg::REG_ACTIVE_LEVELS: active_q  <= cfg_data[kdh_pkg::MAX_KEYS-1:0];
				kdh_pkg::REG_PRESS_THR:     press_q   <= cfg_data[kdh_pkg::COUNT_W-1:0];
				kdh_pkg::REG_RELEASE_THR:   release_q <= cfg_data[kdh_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < kdh_pkg::MAX_KEYS; k++) begin
			key_cfg[k].hold_time    = hold_q[k];
			key_cfg[k].active_level = active_q[k];
			key_cfg[k].press_thr    = press_q;
			key_cfg[k].release_thr  = release_q;
		end
	end

endmodule

`default_nettype wire

>>> hdl/kdh_key.sv
// ----------------------------------------------------------------------------
// Key debounce per-key unit
// Integrating counter, debounced state, hold timer and last event of one key.
// ----------------------------------------------------------------------------
`default_nettype none

module kdh_key (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic                              level,
	input  wire logic [kdh_pkg::TIME_WIDTH-1:0]    now,
	input  wire kdh_pkg::kdh_key_cfg_t             cfg,
	output kdh_pkg::kdh_event_t                    event_next,
	output logic                                   pressed_next
);

	logic [kdh_pkg::COUNT_W-1:0]    count_q;
	logic                           pressed_q;
	logic [kdh_pkg::TIME_WIDTH-1:0] hold_start_q;
	kdh_pkg::kdh_event_t            event_q;

	logic [kdh_pkg::COUNT_W-1:0]    count_next;
	logic [kdh_pkg::TIME_WIDTH-1:0] hold_start_next;
	logic [kdh_pkg::TIME_WIDTH-1:0] elapsed;

	always_comb begin
		if (level == cfg.active_level) begin
			count_next = (count_q >= kdh_pkg::COUNT_MAX) ? kdh_pkg::COUNT_MAX
				: count_q + 7'd1;
		end else begin
			count_next = (count_q <= kdh_pkg::COUNT_MIN) ? kdh_pkg::COUNT_MIN
				: count_q - 7'd1;
		end

		elapsed         = now - hold_start_q;
		pressed_next    = pressed_q;
		event_next      = event_q;
		hold_start_next = hold_start_q;

		if (!pressed_q) begin
			if (count_next > cfg.press_thr) begin
				pressed_next    = 1'b1;
				event_next      = kdh_pkg::EV_PRESSED;
				hold_start_next = now;
			end
		end else begin
			priority if (count_next < cfg.release_thr) begin
				pressed_next = 1'b0;
				event_next   = kdh_pkg::EV_RELEASED;
			end else if (kdh_pkg::HOLD_W'(elapsed) >= cfg.hold_time) begin
				event_next      = kdh_pkg::EV_HELD;
				hold_start_next = now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= kdh_pkg::COUNT_MIN;
			pressed_q    <= 1'b0;
			hold_start_q <= '0;
			event_q      <= kdh_pkg::EV_RELEASED;
		end else if (step) begin
			count_q      <= count_next;
			pressed_q    <= pressed_next;
			hold_start_q <= hold_start_next;
			event_q      <= event_next;
		end
	end

	// The integrating counter never leaves its saturation range.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= kdh_pkg::COUNT_MIN) && (count_q <= kdh_pkg::COUNT_MAX))
		else $error("bounce counter out of range");

endmodule

`default_nettype wire

>>> hdl/key_debounce_hold_detector.sv
// ----------------------------------------------------------------------------
// Key debounce and hold detector
// Debounces three keys with integrating counters and reports press, release
// and repeated hold events together with the debounced key state.
// ----------------------------------------------------------------------------
// One request per clock is taken, at a sustained rate of one per cycle while
// the input is not stalled. Each request is captured in an input register,
// the per-key counters, states and hold timers are updated from it when it
// moves on, and the result is held in an output register written on that same
// edge. A stalled output holds the output register and, once the input
// register is also full, stalls the input; the configuration registers are
// written through the plain write port at once.
`default_nettype none

module key_debounce_hold_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire kdh_pkg::kdh_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output kdh_pkg::kdh_out_t                   out_data,
	input  wire logic                           cfg_we,
	input  wire logic [kdh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kdh_pkg::CFG_DATA_W-1:0] cfg_data
);

	kdh_pkg::kdh_key_cfg_t        key_cfg [kdh_pkg::MAX_KEYS];
	logic                         valid_s1;
	kdh_pkg::kdh_in_t             data_s1;
	logic                         advance;
	kdh_pkg::kdh_event_t          ev_next [kdh_pkg::MAX_KEYS];
	logic [kdh_pkg::MAX_KEYS-1:0] down_next;
	kdh_pkg::kdh_out_t            result;
	logic                         out_valid_q;
	kdh_pkg::kdh_out_t            out_data_q;

	kdh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key_cfg   (key_cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	for (genvar k = 0; k < kdh_pkg::MAX_KEYS; k++) begin : g_key
		if (k < kdh_pkg::NUM_KEYS) begin : g_used
			kdh_key u_key (
				.clk          (clk),
				.arst_n       (arst_n),
				.step         (advance),
				.level        (data_s1.pin_levels[k]),
				.now          (data_s1.now_time[kdh_pkg::TIME_WIDTH-1:0]),
				.cfg          (key_cfg[k]),
				.event_next   (ev_next[k]),
				.pressed_next (down_next[k])
			);
		end else begin : g_unused
			assign ev_next[k]   = kdh_pkg::EV_RELEASED;
			assign down_next[k] = 1'b0;
		end
	end

	always_comb begin
		result.key0_event = ev_next[0];
		result.key1_event = ev_next[1];
		result.key2_event = ev_next[2];
		result.keys_down  = down_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A request waiting in the input register moves on whenever the output is free.
	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |-> !in_stall)
		else $error("input stalled while output register is empty");

	// An accepted request is always held in the input register on the next edge.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request lost");

	// A key reads as down exactly when its last event is not a release.
	a_down_matches_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_data.keys_down[0] == (out_data.key0_event != kdh_pkg::EV_RELEASED)) &&
			(out_data.keys_down[1] == (out_data.key1_event != kdh_pkg::EV_RELEASED)) &&
			(out_data.keys_down[2] == (out_data.key2_event != kdh_pkg::EV_RELEASED)))
		else $error("debounced state disagrees with last event");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debounce and hold detector testbench
// Sends pin sample requests with random gaps and output stalls, predicts each
// key's counter, state and event in step with accepted requests, and compares
// every result field by field. The configuration is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import kdh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	kdh_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	kdh_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [HOLD_W-1:0] hold_cfg [NUM_KEYS];
	logic [NUM_KEYS-1:0] level_cfg;
	logic [COUNT_W-1:0] press_cfg;
	logic [COUNT_W-1:0] release_cfg;
	logic [COUNT_W-1:0] bounce [NUM_KEYS];
	logic [NUM_KEYS-1:0] down_state;
	logic [TIME_WIDTH-1:0] hold_from [NUM_KEYS];
	kdh_event_t key_event [NUM_KEYS];

	kdh_in_t sample_q [$];
	kdh_out_t key_report_q [$];
	kdh_out_t want_report;
	int err_count = 0;
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	bit calm = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	int choke_cycles = 0;
	logic [NUM_KEYS-1:0] run_level = '0;
	int run_left [NUM_KEYS] = '{default: 0};
	logic [TIME_WIDTH-1:0] stamp = '0;

	key_debounce_hold_detector DUT (.*);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		if (err_count < 50) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
		err_count++;
	endtask

	function automatic int draw_wait();
		if (calm) begin
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic kdh_out_t debounce_tick(input kdh_in_t s);
		kdh_out_t r;
		logic [TIME_WIDTH-1:0] elapsed;
		r = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (s.pin_levels[k] == level_cfg[k]) begin
				bounce[k] = (bounce[k] >= COUNT_MAX) ? COUNT_MAX : bounce[k] + 7'd1;
			end else begin
				bounce[k] = (bounce[k] <= COUNT_MIN) ? COUNT_MIN : bounce[k] - 7'd1;
			end
			elapsed = s.now_time - hold_from[k];
			if (!down_state[k]) begin
				if (bounce[k] > press_cfg) begin
					down_state[k] = 1'b1;
					key_event[k] = EV_PRESSED;
					hold_from[k] = s.now_time;
				end
			end else if (bounce[k] < release_cfg) begin
				down_state[k] = 1'b0;
				key_event[k] = EV_RELEASED;
			end else if (elapsed >= hold_cfg[k]) begin
				hold_from[k] = s.now_time;
				key_event[k] = EV_HELD;
			end
		end
		r.key0_event = key_event[0];
		r.key1_event = key_event[1];
		r.key2_event = key_event[2];
		r.keys_down = down_state;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_KEY0: hold_cfg[0] = cfg_data;
					REG_HOLD_KEY1: hold_cfg[1] = cfg_data;
					REG_HOLD_KEY2: hold_cfg[2] = cfg_data;
					REG_ACTIVE_LEVELS: level_cfg = cfg_data[NUM_KEYS-1:0];
					REG_PRESS_THR: press_cfg = cfg_data[COUNT_W-1:0];
					REG_RELEASE_THR: release_cfg = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			in_taken = in_valid && !in_stall;
			out_taken = out_valid && !out_stall;
			if (in_taken) begin
				key_report_q.push_back(debounce_tick(in_data));
			end
			if (out_taken) begin
				if (key_report_q.size() == 0) begin
					flag_mismatch("result with no request outstanding");
				end else begin
					want_report = key_report_q.pop_front();
					if (out_data.key0_event !== want_report.key0_event) begin
						flag_mismatch($sformatf("key0_event got %0d expected %0d",
							out_data.key0_event, want_report.key0_event));
					end
					if (out_data.key1_event !== want_report.key1_event) begin
						flag_mismatch($sformatf("key1_event got %0d expected %0d",
							out_data.key1_event, want_report.key1_event));
					end
					if (out_data.key2_event !== want_report.key2_event) begin
						flag_mismatch($sformatf("key2_event got %0d expected %0d",
							out_data.key2_event, want_report.key2_event));
					end
					if (out_data.keys_down !== want_report.keys_down) begin
						flag_mismatch($sformatf("keys_down got %b expected %b",
							out_data.keys_down, want_report.keys_down));
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (sample_q.size() != 0) begin
				in_data <= sample_q.pop_front();
				in_valid <= 1'b1;
				in_gap = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_gap = draw_wait();
			end
			if (choke_cycles != 0) begin
				out_stall <= 1'b1;
				choke_cycles--;
			end else if (out_gap != 0) begin
				out_stall <= 1'b1;
				out_gap--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_keys(input logic [31:0] h0, input logic [31:0] h1,
		input logic [31:0] h2, input logic [2:0] act, input logic [6:0] prs,
		input logic [6:0] rel);
		logic [31:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
		write_reg(REG_HOLD_KEY0, h0);
		write_reg(REG_HOLD_KEY1, h1);
		write_reg(REG_HOLD_KEY2, h2);
		write_reg(REG_ACTIVE_LEVELS, {junk[31:3], act});
		write_reg(REG_PRESS_THR, {junk[31:7], prs});
		write_reg(REG_RELEASE_THR, {junk[31:7], rel});
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
	endtask

	task automatic push_sample(input logic [2:0] pins, input logic [31:0] t);
		kdh_in_t s;
		s.pin_levels = pins;
		s.now_time = t;
		sample_q.push_back(s);
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || in_valid || key_report_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Each key follows steady pin levels of random length with random
	// bounce flips on top, so that the counters climb past the thresholds.
	task automatic run_phase(input logic [31:0] h0, input logic [31:0] h1,
		input logic [31:0] h2, input logic [2:0] act, input logic [6:0] prs,
		input logic [6:0] rel, input int run_max, input int noise_pct);
		logic [NUM_KEYS-1:0] pins;
		set_keys(h0, h1, h2, act, prs, rel);
		for (int i = 0; i < 180; i++) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (run_left[k] == 0) begin
					run_level[k] = 1'($urandom_range(0, 1));
					run_left[k] = $urandom_range(1, run_max);
				end
				run_left[k]--;
				pins[k] = run_level[k] ^ ($urandom_range(0, 99) < noise_pct);
			end
			if ($urandom_range(0, 49) == 0) begin
				stamp = $urandom;
			end else begin
				stamp = stamp + $urandom_range(0, 3);
			end
			push_sample(pins, stamp);
		end
		drain();
	endtask

	initial begin
		int thr;
		for (int k = 0; k < NUM_KEYS; k++) begin
			hold_cfg[k] = HOLD_RESET;
			bounce[k] = COUNT_MIN;
			hold_from[k] = '0;
			key_event[k] = EV_RELEASED;
		end
		level_cfg = ACTIVE_RESET;
		press_cfg = PRESS_RESET;
		release_cfg = RELEASE_RESET;
		down_state = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_sample(3'b000, 32'h0000_0000);
		push_sample(3'b111, 32'hFFFF_FFFF);
		push_sample(3'b010, 32'h8000_0000);
		push_sample(3'b101, 32'h7FFF_FFFF);
		push_sample(3'b000, 32'h5555_5555);
		push_sample(3'b111, 32'hAAAA_AAAA);
		drain();

		// A zero hold time repeats every tick; an all-ones one barely ever does.
		set_keys(32'd0, 32'hFFFF_FFFF, 32'd3, 3'b101, 7'd2, 7'd3);
		for (int i = 0; i < 6; i++) begin
			push_sample(3'b101, 32'd100 + i);
		end
		for (int i = 0; i < 4; i++) begin
			push_sample(3'b010, 32'd106 + i);
		end
		push_sample(3'b111, 32'hFFFF_FFF0);
		push_sample(3'b111, 32'hFFFF_FFFE);
		push_sample(3'b101, 32'h0000_0002);
		push_sample(3'b101, 32'h0000_0005);
		drain();

		stamp = 32'd200;
		calm = 1'b1;
		run_phase(32'd5, 32'd0, 32'hFFFF_FFFF, 3'b010, 7'd10, 7'd5, 30, 10);
		calm = 1'b0;
		run_phase(32'd0, 32'd1, 32'd20, 3'b111, 7'd100, 7'd50, 150, 5);
		run_phase(32'd30, 32'd30, 32'd30, 3'b000, 7'd2, 7'd2, 20, 30);
		run_phase($urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 64),
			3'($urandom), 7'd127, 7'd0, 60, 50);

		// The receiver holds off long enough for the block to back up its input.
		calm = 1'b1;
		choke_cycles = 200;
		run_phase($urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 64),
			3'($urandom), 7'd99, 7'd100, 120, 3);
		calm = 1'b0;

		stamp = 32'hFFFF_FF00;
		thr = $urandom_range(2, 40);
		run_phase($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
			3'($urandom), 7'(thr), 7'($urandom_range(2, thr)), 50, 8);
		run_phase($urandom, $urandom, $urandom, 3'($urandom), 7'($urandom_range(2, 60)),
			7'($urandom_range(2, 60)), 80, 8);
		run_phase(HOLD_RESET, HOLD_RESET, HOLD_RESET, ACTIVE_RESET, PRESS_RESET,
			RELEASE_RESET, 150, 2);

		repeat (6) @(posedge clk);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
